@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros
// concurrent assertion macros for the flattener
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ hdl/cbf_pkg.sv @@
// ---------------------------------------------------------------------------
// cbf_pkg
// shared types for the cubic bezier flattener
// ---------------------------------------------------------------------------
package cbf_pkg;
   localparam int unsigned LvlWidth = 3;
   localparam int unsigned FlatWidth = 16;
endpackage

@@ hdl/cbf_mult.sv @@
// ---------------------------------------------------------------------------
// cbf_mult
// sequential shift-add signed multiplier, one bit per cycle
// ---------------------------------------------------------------------------
module cbf_mult #(
   parameter int unsigned W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic                done,
   output logic signed [2*W-1:0] prod
);
   localparam int unsigned CW = $clog2(W + 1);
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic [2*W-1:0]   acc_ff;
   logic [2*W-1:0]   mc_ff;
   logic [W-1:0]     mp_ff;
   logic             neg_ff;
   logic [W-1:0]     ua, ub;

   assign ua = a[W-1] ? (~a + 1'b1) : a;
   assign ub = b[W-1] ? (~b + 1'b1) : b;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            acc_ff  <= '0;
            mc_ff   <= {{W{1'b0}}, ua};
            mp_ff   <= ub;
            neg_ff  <= a[W-1] ^ b[W-1];
         end else if (busy_ff) begin
            if (mp_ff[0]) acc_ff <= acc_ff + mc_ff;
            mc_ff <= mc_ff << 1;
            mp_ff <= mp_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   assign prod = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
endmodule

@@ hdl/cubic_bezier_flattener_unit.sv @@
// ---------------------------------------------------------------------------
// cubic_bezier_flattener_unit
// adaptive subdivision of one cubic bezier curve into line segments
// ---------------------------------------------------------------------------
// usage: one curve transfer on req_ (four control points), then one rsp_
// transfer per segment end point, last_seg on the final one. a new curve is
// taken only after its predecessor's last segment transfer.
// the flatness test runs through one shared bit-serial signed multiplier of
// MW bits (52 at the default width): ten products per test (chord length,
// f*f, limit, two cross products and a square per inner point), run one
// after the other. a curve with equal end points skips the test and goes
// straight to its segment. a curve at the depth bound tests 63 subcurves;
// a curve yields 1 to 2^MAX_DEPTH segments.
// pending right halves sit in a synchronous stack memory (one row per
// level: 8 coordinates plus level), read through a register.
// reset (synchronous) empties the stack and loads tolerance 256; memory
// content needs no clearing. a stalled rsp_ holds the segment and freezes
// the engine. csr_ writes must be made while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module cubic_bezier_flattener_unit #(
   parameter int unsigned MAX_DEPTH   = 6,
   parameter int unsigned COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl1_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl1_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl2_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl2_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_pt_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_pt_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_x,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_y,
   output logic                          rsp_last_seg,
   input  logic                          csr_write_enable,
   input  logic [cbf_pkg::FlatWidth-1:0] csr_write_data
);
   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned LW = cbf_pkg::LvlWidth;
   // wide enough for the cross products and for chord length times f*f
   localparam int unsigned MW = (2 * COORD_WIDTH + 4 > 36) ? 2 * COORD_WIDTH + 4 : 36;
   localparam int unsigned SW = $clog2(MAX_DEPTH + 1);
   localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned RW = 8 * CW + LW;
   localparam logic [3:0]  StepCount = 4'd10;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_TEST = 9'b000000010, S_MUL  = 9'b000000100,
      S_DEC  = 9'b000001000, S_SPL  = 9'b000010000, S_OUT  = 9'b000100000,
      S_POP  = 9'b001000000, S_LOAD = 9'b010000000, S_WAIT = 9'b100000000
   } state_type;

   state_type state_ff;
   logic signed [CW-1:0] px_ff [4];
   logic signed [CW-1:0] py_ff [4];
   logic [LW-1:0]  lvl_ff;
   logic [SW-1:0]  top_ff;
   logic [cbf_pkg::FlatWidth-1:0] tol_ff;
   logic [3:0]     step_ff;
   logic signed [MW-1:0] d_ff, t_ff, f2_ff;
   logic [2*MW-1:0] lim_ff;
   logic           ok_ff;
   logic [RW-1:0]  stack_mem [MAX_DEPTH];
   logic [RW-1:0]  rd_ff;
   logic           mstart;
   logic signed [MW-1:0] ma, mb;
   logic           mdone;
   logic signed [2*MW-1:0] mprod;

   cbf_mult #(.W(MW)) u_mult (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(mprod)
   );

   // chord and offsets, sign extended to the multiplier width
   logic signed [MW-1:0] dx, dy, ex1, ey1, ex2, ey2;
   assign dx  = MW'(px_ff[3]) - MW'(px_ff[0]);
   assign dy  = MW'(py_ff[3]) - MW'(py_ff[0]);
   assign ex1 = MW'(px_ff[1]) - MW'(px_ff[0]);
   assign ey1 = MW'(py_ff[1]) - MW'(py_ff[0]);
   assign ex2 = MW'(px_ff[2]) - MW'(px_ff[0]);
   assign ey2 = MW'(py_ff[2]) - MW'(py_ff[0]);

   // product sequence: dx*dx, dy*dy, f*f, len*f*f,
   // dx*ey1, dy*ex1, d*d, dx*ey2, dy*ex2, d*d
   always_comb begin
      case (step_ff)
         4'd0: begin ma = dx; mb = dx; end
         4'd1: begin ma = dy; mb = dy; end
         4'd2: begin ma = MW'(tol_ff); mb = MW'(tol_ff); end
         4'd3: begin ma = t_ff; mb = f2_ff; end
         4'd4: begin ma = dx; mb = ey1; end
         4'd5: begin ma = dy; mb = ex1; end
         4'd6: begin ma = d_ff; mb = d_ff; end
         4'd7: begin ma = dx; mb = ey2; end
         4'd8: begin ma = dy; mb = ex2; end
         default: begin ma = d_ff; mb = d_ff; end
      endcase
   end
   assign mstart = (state_ff == S_TEST);

   // de casteljau split, floor averages
   function automatic logic signed [CW-1:0] avg(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
      logic signed [CW:0] s;
      s = {a[CW-1], a} + {b[CW-1], b};
      return s[CW:1];
   endfunction
   logic signed [CW-1:0] lx[4], rx[4], ly[4], ry[4];
   always_comb begin
      logic signed [CW-1:0] a, m, b, la, rb, mid;
      a = avg(px_ff[0], px_ff[1]); m = avg(px_ff[1], px_ff[2]);
      b = avg(px_ff[2], px_ff[3]); la = avg(a, m); rb = avg(m, b);
      mid = avg(la, rb);
      lx[0] = px_ff[0]; lx[1] = a; lx[2] = la; lx[3] = mid;
      rx[0] = mid; rx[1] = rb; rx[2] = b; rx[3] = px_ff[3];
      a = avg(py_ff[0], py_ff[1]); m = avg(py_ff[1], py_ff[2]);
      b = avg(py_ff[2], py_ff[3]); la = avg(a, m); rb = avg(m, b);
      mid = avg(la, rb);
      ly[0] = py_ff[0]; ly[1] = a; ly[2] = la; ly[3] = mid;
      ry[0] = mid; ry[1] = rb; ry[2] = b; ry[3] = py_ff[3];
   end

   logic degen;
   assign degen = (px_ff[0] == px_ff[3]) && (py_ff[0] == py_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         top_ff    <= '0;
         tol_ff    <= 16'd256;
         rsp_valid <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (csr_write_enable) tol_ff <= csr_write_data;
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               px_ff[0] <= req_start_x; px_ff[1] <= req_ctrl1_x;
               px_ff[2] <= req_ctrl2_x; px_ff[3] <= req_end_pt_x;
               py_ff[0] <= req_start_y; py_ff[1] <= req_ctrl1_y;
               py_ff[2] <= req_ctrl2_y; py_ff[3] <= req_end_pt_y;
               lvl_ff <= '0; top_ff <= '0;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (degen || lvl_ff >= LW'(MAX_DEPTH) || top_ff >= SW'(MAX_DEPTH))
                  state_ff <= S_OUT;
               else begin
                  step_ff <= '0; ok_ff <= 1'b1;
                  state_ff <= S_TEST;
               end
            end
            S_TEST: state_ff <= S_MUL;
            S_MUL: if (mdone) begin
               case (step_ff) inside
                  4'd0: t_ff <= mprod[MW-1:0];
                  4'd1: t_ff <= t_ff + mprod[MW-1:0];
                  4'd2: f2_ff <= mprod[MW-1:0];
                  4'd3: lim_ff <= mprod;
                  4'd4, 4'd7: d_ff <= mprod[MW-1:0];
                  4'd5, 4'd8: d_ff <= d_ff - mprod[MW-1:0];
                  // d^2*2^16 <= f^2*len, exact at full width
                  default: if ({mprod, 16'b0} > {16'b0, lim_ff}) ok_ff <= 1'b0;
               endcase
               step_ff  <= step_ff + 4'd1;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (step_ff == StepCount) state_ff <= S_SPL;
               else state_ff <= S_TEST;
            end
            S_SPL: begin
               if (ok_ff) state_ff <= S_OUT;
               else begin
                  stack_mem[top_ff[AW-1:0]] <= {rx[0], rx[1], rx[2], rx[3],
                                               ry[0], ry[1], ry[2], ry[3],
                                               LW'(lvl_ff + 1'b1)};
                  px_ff <= lx; py_ff <= ly;
                  lvl_ff <= lvl_ff + 1'b1;
                  top_ff <= top_ff + 1'b1;
                  state_ff <= S_DEC;
               end
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_seg_x <= px_ff[3]; rsp_seg_y <= py_ff[3];
                  rsp_last_seg <= (top_ff == '0);
                  rsp_valid <= 1'b1;
               end else if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  if (rsp_last_seg) state_ff <= S_IDLE;
                  else begin
                     top_ff <= top_ff - 1'b1;
                     state_ff <= S_POP;
                  end
               end
            end
            S_POP: begin
               rd_ff <= stack_mem[top_ff[AW-1:0]];
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               px_ff[0] <= rd_ff[RW-1 -: CW];      px_ff[1] <= rd_ff[RW-1-CW -: CW];
               px_ff[2] <= rd_ff[RW-1-2*CW -: CW]; px_ff[3] <= rd_ff[RW-1-3*CW -: CW];
               py_ff[0] <= rd_ff[RW-1-4*CW -: CW]; py_ff[1] <= rd_ff[RW-1-5*CW -: CW];
               py_ff[2] <= rd_ff[RW-1-6*CW -: CW]; py_ff[3] <= rd_ff[RW-1-7*CW -: CW];
               lvl_ff <= rd_ff[LW-1:0];
               state_ff <= S_DEC;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `ASSERT_IMPLIES(a_top_bound, clock, reset, 1'b1, top_ff <= SW'(MAX_DEPTH))
   `ASSERT_IMPLIES(a_valid_out, clock, reset, rsp_valid, state_ff == S_OUT)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_seg_x) && $stable(rsp_seg_y))
endmodule

@@ verif/cubic_bezier_flattener_unit_test.sv @@
// ---------------------------------------------------------------------------
// cubic_bezier_flattener_unit_test
// self-checking bench: curves go in on req_, segment end points are checked
// against an in-bench subdivision predictor, tolerance swept across phases
// ---------------------------------------------------------------------------
module cubic_bezier_flattener_unit_test;

   localparam int unsigned CoordWidth = 24;
   localparam int unsigned TreeDepth  = 6;
   localparam longint      CycleLimit = 40000000;
   localparam int          SettleCycles = 600;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [127:0] wide_type;
   typedef longint quad_type[4];

   // one curve: x0 y0 x1 y1 x2 y2 x3 y3
   typedef struct {
      coord_type pt[8];
      bit        typed;
      coord_type end_x;
      coord_type end_y;
   } curve_row_type;

   typedef struct {
      coord_type x;
      coord_type y;
      bit        last;
   } segment_type;

   localparam coord_type CoordMax = coord_type'((1 << (CoordWidth - 1)) - 1);
   localparam coord_type CoordMin = coord_type'(1 << (CoordWidth - 1));

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   coord_type                     req_pt[8];
   logic                          rsp_valid;
   logic                          rsp_stall;
   coord_type                     rsp_seg_x;
   coord_type                     rsp_seg_y;
   logic                          rsp_last_seg;
   logic                          csr_write_enable;
   logic [cbf_pkg::FlatWidth-1:0] csr_write_data;

   // predictor state: current tolerance and the segments still owed
   logic [cbf_pkg::FlatWidth-1:0] tolerance;
   segment_type                   owed_segments[$];
   curve_row_type                 directed_curves[$];
   int                            send_idle_pct;
   int                            recv_idle_pct;
   int                            mismatches;
   longint                        cycles;

   cubic_bezier_flattener_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_x      (req_pt[0]),
      .req_start_y      (req_pt[1]),
      .req_ctrl1_x      (req_pt[2]),
      .req_ctrl1_y      (req_pt[3]),
      .req_ctrl2_x      (req_pt[4]),
      .req_ctrl2_y      (req_pt[5]),
      .req_end_pt_x     (req_pt[6]),
      .req_end_pt_y     (req_pt[7]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seg_x        (rsp_seg_x),
      .rsp_seg_y        (rsp_seg_y),
      .rsp_last_seg     (rsp_last_seg),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // floored midpoint, same as an arithmetic shift of the sum
   function automatic longint midpoint(longint a, longint b);
      return (a + b) >>> 1;
   endfunction

   // true when both inner points lie within tolerance of the chord
   function automatic bit chord_is_flat(quad_type x, quad_type y);
      wide_type dx, dy, d, lim;
      wide_type f;
      bit       ok;
      dx  = wide_type'(x[3] - x[0]);
      dy  = wide_type'(y[3] - y[0]);
      f   = wide_type'({1'b0, tolerance});
      lim = f * f * (dx * dx + dy * dy);
      ok  = 1'b1;
      for (int i = 1; i <= 2; i++) begin
         d = dx * wide_type'(y[i] - y[0]) - dy * wide_type'(x[i] - x[0]);
         if (d * d * wide_type'(65536) > lim)
            ok = 1'b0;
      end
      return ok;
   endfunction

   // de casteljau split at t = 1/2
   function automatic void halve(input quad_type p, output quad_type l,
                                 output quad_type r);
      longint a, m, b, la, rb, mid;
      a   = midpoint(p[0], p[1]);
      m   = midpoint(p[1], p[2]);
      b   = midpoint(p[2], p[3]);
      la  = midpoint(a, m);
      rb  = midpoint(m, b);
      mid = midpoint(la, rb);
      l = '{p[0], a, la, mid};
      r = '{mid, rb, b, p[3]};
   endfunction

   // walks the subdivision tree left first, queueing every segment end point
   function automatic void predict_segments(coord_type pt[8]);
      quad_type    cx, cy, lx, ly;
      quad_type    held_x[TreeDepth];
      quad_type    held_y[TreeDepth];
      int          held_level[TreeDepth];
      int          top, level;
      bit          emit;
      segment_type s;
      for (int i = 0; i < 4; i++) begin
         cx[i] = longint'(pt[2*i]);
         cy[i] = longint'(pt[2*i+1]);
      end
      top = 0;
      level = 0;
      forever begin
         emit = (cx[0] == cx[3] && cy[0] == cy[3]) || chord_is_flat(cx, cy)
                || level >= TreeDepth || top >= TreeDepth;
         if (emit) begin
            s.x = coord_type'(cx[3]);
            s.y = coord_type'(cy[3]);
            s.last = (top == 0);
            owed_segments.push_back(s);
            if (top == 0)
               break;
            top--;
            cx = held_x[top];
            cy = held_y[top];
            level = held_level[top];
         end else begin
            halve(cx, lx, held_x[top]);
            halve(cy, ly, held_y[top]);
            held_level[top] = level + 1;
            top++;
            cx = lx;
            cy = ly;
            level++;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   function automatic void add_row(coord_type x0, coord_type y0, coord_type x1,
                                   coord_type y1, coord_type x2, coord_type y2,
                                   coord_type x3, coord_type y3, bit typed);
      curve_row_type r;
      r.pt = '{x0, y0, x1, y1, x2, y2, x3, y3};
      r.typed = typed;
      r.end_x = x3;
      r.end_y = y3;
      directed_curves.push_back(r);
   endfunction

   // mostly well-formed curves: degenerate chords, straight runs with a
   // little bend, small wiggles; now and then a full-range curve that
   // goes all the way to the depth bound
   function automatic void random_curve(output coord_type pt[8]);
      int     kind, ax, ay, k1, k2, k3;
      longint bx, by;
      kind = $urandom_range(0, 99);
      foreach (pt[i]) pt[i] = any_coord();
      if (kind < 20) begin
         pt[6] = pt[0];
         pt[7] = pt[1];
      end else if (kind < 62) begin
         bx = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
         by = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
         ax = $signed($urandom_range(0, 8192)) - 4096;
         ay = $signed($urandom_range(0, 8192)) - 4096;
         k1 = $signed($urandom_range(0, 400)) - 200;
         k2 = $signed($urandom_range(0, 400)) - 200;
         k3 = $urandom_range(1, 400);
         pt[0] = coord_type'(bx);
         pt[1] = coord_type'(by);
         pt[2] = coord_type'(bx + k1 * ax);
         pt[3] = coord_type'(by + k1 * ay);
         pt[4] = coord_type'(bx + k2 * ax);
         pt[5] = coord_type'(by + k2 * ay);
         pt[6] = coord_type'(bx + k3 * ax);
         pt[7] = coord_type'(by + k3 * ay);
         // bend the inner points a few lsb on half of them
         if ($urandom_range(0, 1)) begin
            for (int i = 2; i < 6; i++)
               pt[i] = pt[i] + coord_type'($signed($urandom_range(0, 6)) - 3);
         end
      end else if (kind < 95) begin
         bx = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
         by = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
         for (int i = 0; i < 4; i++) begin
            pt[2*i]   = coord_type'(bx + $signed($urandom_range(0, 16)) - 8);
            pt[2*i+1] = coord_type'(by + $signed($urandom_range(0, 16)) - 8);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   task automatic send_curve(coord_type pt[8]);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      foreach (pt[i]) req_pt[i] <= pt[i];
      do @(posedge clock);
      while (req_stall);
   endtask

   // register writes only once the block has gone quiet
   task automatic set_tolerance(logic [cbf_pkg::FlatWidth-1:0] value);
      req_valid <= 1'b0;
      while (owed_segments.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance = value;
   endtask

   task automatic run_random(int count, bit pause_midway);
      coord_type pt[8];
      for (int n = 0; n < count; n++) begin
         // drain completely once so the sender sits idle on an empty pipe
         if (pause_midway && n == count / 2) begin
            req_valid <= 1'b0;
            while (owed_segments.size() != 0)
               @(posedge clock);
         end
         random_curve(pt);
         send_curve(pt);
         predict_segments(pt);
      end
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (owed_segments.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected segment transfer x=%0d y=%0d last=%0b",
                           rsp_seg_x, rsp_seg_y, rsp_last_seg);
            end else begin
               segment_type s;
               s = owed_segments.pop_front();
               if (s.x !== rsp_seg_x || s.y !== rsp_seg_y || s.last !== rsp_last_seg) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("segment mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              s.x, s.y, s.last, rsp_seg_x, rsp_seg_y, rsp_last_seg);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("cubic_bezier_flattener_unit_test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      foreach (req_pt[i]) req_pt[i] <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      tolerance        = 16'd256;
      mismatches       = 0;
      cycles           = 0;
      send_idle_pct    = 14;
      recv_idle_pct    = 53;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // degenerate chord at zero and at the extremes, inner points anywhere
      add_row(0, 0, CoordMax, CoordMin, CoordMin, CoordMax, 0, 0, 1);
      add_row(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
              CoordMax, CoordMin, 1);
      add_row(CoordMin, CoordMax, 0, 0, CoordMin, CoordMin, CoordMin, CoordMax, 1);
      // exact straight lines pass at once
      add_row(0, 0, 256, 0, 512, 0, 768, 0, 1);
      add_row(CoordMin, CoordMin, -100, -100, 100, 100, CoordMax, CoordMax, 1);
      add_row(CoordMax, 0, 0, 0, CoordMin + 1, 0, CoordMin, 0, 1);
      // full-range bends run into the depth bound
      add_row(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
              CoordMax, CoordMax, 0);
      add_row(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
              CoordMax, CoordMin, 0);
      // odd sums and negative values exercise the floored average
      add_row(-3, -5, 7, -9, -11, 13, 5, 3, 0);
      add_row(-1, -1, 0, 1, 1, 0, 1, -1, 0);
      // slight bend, just past one lsb, then a wide arch
      add_row(0, 0, 1000, 2, 2000, -2, 3000, 0, 0);
      add_row(100, 100, 100, 5000, 5000, 5000, 5000, 100, 0);

      foreach (directed_curves[i]) begin
         send_curve(directed_curves[i].pt);
         if (directed_curves[i].typed)
            owed_segments.push_back('{directed_curves[i].end_x,
                                      directed_curves[i].end_y, 1'b1});
         else
            predict_segments(directed_curves[i].pt);
      end

      // zero tolerance: only exact lines pass
      set_tolerance(16'd0);
      run_random(85, 1'b0);

      send_idle_pct = 53;
      recv_idle_pct = 14;
      set_tolerance(16'hFFFF);
      run_random(85, 1'b1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_tolerance(16'($urandom_range(1, 2048)));
      run_random(45, 1'b0);
      set_tolerance(16'($urandom));
      run_random(40, 1'b0);

      req_valid <= 1'b0;
      while (owed_segments.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && owed_segments.size() == 0)
         $display("cubic_bezier_flattener_unit_test passed");
      else
         $display("cubic_bezier_flattener_unit_test failed");
      $finish;
   end

endmodule
